// ===== sv/ssra_pkg.sv =====
// Shared constants and types for the swap slot run allocator.
`default_nettype none

package ssra_pkg;

    // Map geometry
    localparam int MAX_SECTORS = 8192;
    localparam int RUN_LENGTH  = 8;
    localparam int WORD_W      = 64;
    localparam int MAP_WORDS   = MAX_SECTORS / WORD_W;
    localparam int MAP_AW      = $clog2(MAP_WORDS);
    localparam int BIT_AW      = $clog2(WORD_W);

    // Field and register widths
    localparam int START_W  = 13;
    localparam int LIMIT_W  = 14;
    localparam int WCNT_W   = MAP_AW + 1;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Mask of one run, aligned to bit zero
    localparam logic [WORD_W-1:0] RUN_MASK = {WORD_W{1'b1}} >> (WORD_W - RUN_LENGTH);

    // Register index of usable_sectors (taken from paddr[2])
    localparam logic CFG_IDX_USABLE = 1'b0;
    localparam logic [LIMIT_W-1:0] USABLE_RESET = LIMIT_W'(MAX_SECTORS);

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD_RD0,
        S_UPD_MOD0,
        S_UPD_RD1,
        S_UPD_MOD1,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/ssra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ssra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/swap_slot_run_allocator.sv =====
// Top level of the swap slot run allocator: free map in RAM, scan and update sequencer.
//
// Channels: input i_valid / o_ready carries one item, i_operation selecting
//   allocate or release and i_release_start giving the first sector to release;
//   output o_valid / i_ready returns one item per input item, o_status and
//   o_slot_start. The APB port holds usable_sectors at byte address 0 (reset
//   8192); write it only while the block is idle.
// Steps: a release clears the run in the map word that holds it, and in the next
//   word when the run crosses a map word; one that runs past the end answers with
//   a bad index. An allocate reads one 64-bit map word per cycle, at most 128
//   words for 8192 sectors, stops at the first word with a hit and sets the run in
//   the same way; with no space, or with no usable sectors, it answers no space.
//   One item is in work at a time; the next is taken in the cycle after the
//   result has moved to the output register.
// Reset: synchronous, active low. A valid bit per map word is cleared, so the
//   whole map reads as free at once; no clearing pass is needed.
// Stall: while a result waits in the output register the next item is still
//   taken and worked on; it waits at its end until the output register is free.
`default_nettype none

module swap_slot_run_allocator
    import ssra_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_operation,
    input  wire logic [START_W-1:0] i_release_start,
    // Output channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [1:0]         o_status,
    output logic      [START_W-1:0] o_slot_start,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // Control and datapath registers
    t_state               r_state, n_state;
    logic [LIMIT_W-1:0]   r_usable;
    logic [LIMIT_W-1:0]   r_limit, n_limit;
    logic [WCNT_W-1:0]    r_nwords, n_nwords;
    logic [WCNT_W-1:0]    r_issue, n_issue;
    logic [MAP_AW-1:0]    r_proc, n_proc;
    logic                 r_pend, n_pend;
    logic [RUN_LENGTH-1:0] r_prev_free, n_prev_free;
    logic [START_W-1:0]   r_start, n_start;
    logic                 r_set, n_set;
    t_status              r_status, n_status;
    logic [START_W-1:0]   r_slot, n_slot;
    logic [MAP_WORDS-1:0] r_row_vld;
    logic                 r_rd_vld;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [START_W-1:0]   r_out_slot, n_out_slot;

    // RAM interface
    logic                 ram_we;
    logic [MAP_AW-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [MAP_AW-1:0]    ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    // Datapath signals
    logic [WORD_W-1:0]            rd_word;
    logic [WORD_W+RUN_LENGTH-1:0] ext_free;
    logic [LIMIT_W-1:0]           limit_eff;
    logic [LIMIT_W:0]             nwords_sum;
    logic [LIMIT_W-1:0]           scan_base;
    logic [LIMIT_W-1:0]           scan_rem;
    logic [WORD_W-1:0]            hit;
    logic                         hit_any;
    logic [BIT_AW-1:0]            hit_pos;
    logic [LIMIT_W-1:0]           hit_start;
    logic [LIMIT_W:0]             rel_end;
    logic [2*WORD_W-1:0]          upd_mask;
    logic [MAP_AW-1:0]            upd_word;
    logic                         cfg_wr;

    ssra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration register and read-back
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_USABLE) ? PDATA_W'(r_usable) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= USABLE_RESET;
        end else if (cfg_wr && (paddr[2] == CFG_IDX_USABLE)) begin
            r_usable <= pwdata[LIMIT_W-1:0];
        end
    end

    // Clamp the usable count and work out how many words to scan
    assign limit_eff  = (r_usable > USABLE_RESET) ? USABLE_RESET : r_usable;
    assign nwords_sum = {1'b0, limit_eff} + (LIMIT_W+1)'(WORD_W - 1);
    assign rel_end    = (LIMIT_W+1)'(i_release_start) + (LIMIT_W+1)'(RUN_LENGTH);

    // Map word as read: rows never written read as free
    assign rd_word  = r_rd_vld ? ram_rdata : '0;
    assign ext_free = {~rd_word, r_prev_free};

    // Find run ends within the current word and below the limit
    assign scan_base = {{(LIMIT_W-MAP_AW-BIT_AW){1'b0}}, r_proc, {BIT_AW{1'b0}}};
    assign scan_rem  = r_limit - scan_base;

    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            hit[j] = (&ext_free[j+1 +: RUN_LENGTH]) && (LIMIT_W'(j) < scan_rem);
        end
    end

    // Lowest run end wins
    always_comb begin
        hit_any = 1'b0;
        hit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_any = 1'b1;
                hit_pos = BIT_AW'(j);
            end
        end
    end

    assign hit_start = scan_base + LIMIT_W'(hit_pos) + LIMIT_W'(1) - LIMIT_W'(RUN_LENGTH);

    // Run mask over the word holding the start and the word after it
    assign upd_word = r_start[START_W-1 -: MAP_AW];
    assign upd_mask = {{WORD_W{1'b0}}, RUN_MASK} << r_start[BIT_AW-1:0];

    // State register and item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit      <= n_limit;
        r_nwords     <= n_nwords;
        r_issue      <= n_issue;
        r_proc       <= n_proc;
        r_prev_free  <= n_prev_free;
        r_start      <= n_start;
        r_set        <= n_set;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    // Row valid bits: clear at reset, set on first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (ram_we) begin
                r_row_vld[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_row_vld[ram_raddr];
            end
        end
    end

    // Sequencer: next state, RAM accesses and result
    always_comb begin
        n_state      = r_state;
        n_limit      = r_limit;
        n_nwords     = r_nwords;
        n_issue      = r_issue;
        n_proc       = r_proc;
        n_pend       = 1'b0;
        n_prev_free  = r_prev_free;
        n_start      = r_start;
        n_set        = r_set;
        n_status     = r_status;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        ram_we       = 1'b0;
        ram_waddr    = upd_word;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = upd_word;
        o_ready      = 1'b0;

        // Drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_limit = limit_eff;
                    n_slot  = '0;
                    if (t_op'(i_operation) == OP_RELEASE) begin
                        if (rel_end > {1'b0, limit_eff}) begin
                            n_status = ST_BAD_INDEX;
                            n_state  = S_DONE;
                        end else begin
                            n_status = ST_OK;
                            n_start  = i_release_start;
                            n_set    = 1'b0;
                            n_state  = S_UPD_RD0;
                        end
                    end else begin
                        n_nwords    = nwords_sum[BIT_AW +: WCNT_W];
                        n_issue     = '0;
                        n_proc      = '0;
                        n_prev_free = '0;
                        if (limit_eff == '0) begin
                            n_status = ST_NO_SPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Issue one word read per cycle
                if (r_issue < r_nwords) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_issue[MAP_AW-1:0];
                    n_issue   = r_issue + WCNT_W'(1);
                    n_pend    = 1'b1;
                end
                // Check the word that has come back
                if (r_pend) begin
                    if (hit_any) begin
                        n_start  = hit_start[START_W-1:0];
                        n_slot   = hit_start[START_W-1:0];
                        n_set    = 1'b1;
                        n_status = ST_OK;
                        n_pend   = 1'b0;
                        n_state  = S_UPD_RD0;
                    end else if (WCNT_W'(r_proc) == r_nwords - WCNT_W'(1)) begin
                        n_status = ST_NO_SPACE;
                        n_pend   = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        n_proc      = r_proc + MAP_AW'(1);
                        n_prev_free = ext_free[WORD_W+RUN_LENGTH-1 -: RUN_LENGTH];
                    end
                end
            end

            S_UPD_RD0: begin
                ram_re  = 1'b1;
                n_state = S_UPD_MOD0;
            end

            S_UPD_MOD0: begin
                ram_we    = 1'b1;
                ram_wdata = r_set ? (rd_word | upd_mask[WORD_W-1:0])
                                  : (rd_word & ~upd_mask[WORD_W-1:0]);
                n_state   = (upd_mask[2*WORD_W-1:WORD_W] != '0) ? S_UPD_RD1 : S_DONE;
            end

            S_UPD_RD1: begin
                ram_re    = 1'b1;
                ram_raddr = upd_word + MAP_AW'(1);
                n_state   = S_UPD_MOD1;
            end

            S_UPD_MOD1: begin
                ram_we    = 1'b1;
                ram_waddr = upd_word + MAP_AW'(1);
                ram_wdata = r_set ? (rd_word | upd_mask[2*WORD_W-1:WORD_W])
                                  : (rd_word & ~upd_mask[2*WORD_W-1:WORD_W]);
                n_state   = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_slot   = r_slot;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_slot_start = r_out_slot;

endmodule

`default_nettype wire

// ===== sv/ssra_checker.sv =====
// Port-level checker for the swap slot run allocator, bound to the top level.
`default_nettype none

module ssra_port_checker
    import ssra_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [1:0]         o_status,
    input wire logic [START_W-1:0] o_slot_start,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pready
);

    // One item at a time: the input is closed right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken again right after an accept");

    // A stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_slot_start)))
        else $error("stalled result changed");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NO_SPACE ||
                     o_status == ST_BAD_INDEX))
        else $error("undefined status code");

    // A failed item carries a zero start
    a_fail_zero_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_slot_start == '0))
        else $error("non-zero start on a failed item");

    // Configuration access completes in its access cycle
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("configuration access stalled");

endmodule

bind swap_slot_run_allocator ssra_port_checker u_ssra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_slot_start (o_slot_start),
    .psel         (psel),
    .penable      (penable),
    .pready       (pready)
);

`default_nettype wire
